[rtl/div64_pkg.sv]
// Package: opcodes, fault codes and transaction structs for the divide unit.
`default_nettype none
package div64_pkg;

  localparam int unsigned FieldW = 64;

  typedef enum logic [1:0] {
    OP_UQUO = 2'd0,
    OP_UREM = 2'd1,
    OP_SQUO = 2'd2,
    OP_SREM = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    FAULT_NONE = 2'd0,
    FAULT_DIV0 = 2'd1,
    FAULT_OVFL = 2'd2,
    FAULT_RSVD = 2'd3
  } fault_t;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [FieldW-1:0] dividend;
    logic [FieldW-1:0] divisor;
  } in_item_t;

  typedef struct packed {
    logic [FieldW-1:0] answer;
    logic [1:0]        fault;
  } out_item_t;

  // Control carried along with each division down the pipeline.
  typedef struct packed {
    logic   want_rem;
    logic   neg_res;
    fault_t fault;
  } ctl_t;

endpackage
`default_nettype wire

[rtl/div64_front.sv]
// Front end: classifies a transaction, takes magnitudes and queues the work.
`default_nettype none
module div64_front
  import div64_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_item_t              in_data,
  output logic                       q_valid,
  input  wire logic                  q_stall,
  output logic [DATA_WIDTH-1:0]      q_num,
  output logic [DATA_WIDTH-1:0]      q_den,
  output ctl_t                       q_ctl
);

  localparam logic [DATA_WIDTH-1:0] SignBit = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam logic [DATA_WIDTH-1:0] AllOnes = {DATA_WIDTH{1'b1}};

  logic [DATA_WIDTH-1:0] a, b, a_mag, b_mag;
  logic                  a_neg, b_neg, is_signed;
  op_t                   op;
  ctl_t                  ctl;

  // Two-entry queue so each side stalls on its own without a combinational path.
  logic [DATA_WIDTH-1:0] num_r [2];
  logic [DATA_WIDTH-1:0] den_r [2];
  ctl_t                  ctl_r [2];
  logic                  wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]            cnt_r, cnt_nxt;
  logic                  push, pop;

  always_comb begin
    a         = in_data.dividend[DATA_WIDTH-1:0];
    b         = in_data.divisor[DATA_WIDTH-1:0];
    op        = op_t'(in_data.opcode);
    is_signed = (op == OP_SQUO) || (op == OP_SREM);
    a_neg     = is_signed && a[DATA_WIDTH-1];
    b_neg     = is_signed && b[DATA_WIDTH-1];
    a_mag     = a_neg ? (~a + 1'b1) : a;
    b_mag     = b_neg ? (~b + 1'b1) : b;
    ctl.want_rem = (op == OP_UREM) || (op == OP_SREM);
    ctl.neg_res  = ctl.want_rem ? a_neg : (a_neg ^ b_neg);
    if (b == '0) begin
      ctl.fault = FAULT_DIV0;
    end else if (op == OP_SQUO && a == SignBit && b == AllOnes) begin
      ctl.fault = FAULT_OVFL;
    end else begin
      ctl.fault = FAULT_NONE;
    end
  end

  assign in_stall = cnt_r[1];
  assign push     = in_valid && !in_stall;
  assign q_valid  = cnt_r != 2'd0;
  assign pop      = q_valid && !q_stall;
  assign q_num    = num_r[rp_r];
  assign q_den    = den_r[rp_r];
  assign q_ctl    = ctl_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      num_r[wp_r] <= a_mag;
      den_r[wp_r] <= b_mag;
      ctl_r[wp_r] <= ctl;
    end
  end

endmodule
`default_nettype wire

[rtl/div64_back.sv]
// Back end: restoring divide pipeline, one quotient bit per stage, and sign fix.
`default_nettype none
module div64_back
  import div64_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  q_valid,
  output logic                       q_stall,
  input  wire logic [DATA_WIDTH-1:0] q_num,
  input  wire logic [DATA_WIDTH-1:0] q_den,
  input  wire ctl_t                  q_ctl,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_item_t                  out_data
);

  localparam int unsigned N = DATA_WIDTH;

  // Stage k holds the partial remainder and quotient after k rows.
  logic [N-1:0] rem_r [N+1];
  logic [N-1:0] quo_r [N+1];
  logic [N-1:0] den_r [N+1];
  ctl_t         ctl_r [N+1];
  logic [N:0]   vld_r;
  logic         adv;

  logic              out_valid_r;
  logic [N-1:0]      res_sel;
  logic [FieldW-1:0] ans_nxt;
  logic [FieldW-1:0] ans_r;
  logic [1:0]        flt_r;

  // Whole pipeline moves together; it holds only when the output is full and stalled.
  assign adv     = !(out_valid_r && out_stall);
  assign q_stall = !adv;

  assign vld_r[0] = q_valid;
  assign rem_r[0] = '0;
  assign quo_r[0] = q_num;
  assign den_r[0] = q_den;
  assign ctl_r[0] = q_ctl;

  for (genvar k = 0; k < N; k++) begin : g_row
    logic [N:0]   shifted;
    logic [N:0]   diff;
    logic         take;
    logic [N-1:0] rem_nxt;
    logic [N-1:0] quo_nxt;
    logic [N-1:0] rem_q;
    logic [N-1:0] quo_q;
    logic [N-1:0] den_q;
    ctl_t         ctl_q;
    logic         vld_q;

    // Dividend bits shift out of quo at the top as quotient bits enter at the bottom.
    always_comb begin
      shifted = {rem_r[k], quo_r[k][N-1]};
      diff    = shifted - {1'b0, den_r[k]};
      take    = !diff[N];
      rem_nxt = take ? diff[N-1:0] : shifted[N-1:0];
      quo_nxt = {quo_r[k][N-2:0], take};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_q <= 1'b0;
      end else if (adv) begin
        vld_q <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_q <= rem_nxt;
        quo_q <= quo_nxt;
        den_q <= den_r[k];
        ctl_q <= ctl_r[k];
      end
    end

    assign vld_r[k+1] = vld_q;
    assign rem_r[k+1] = rem_q;
    assign quo_r[k+1] = quo_q;
    assign den_r[k+1] = den_q;
    assign ctl_r[k+1] = ctl_q;
  end

  always_comb begin
    res_sel = ctl_r[N].want_rem ? rem_r[N] : quo_r[N];
    if (ctl_r[N].neg_res) begin
      res_sel = ~res_sel + 1'b1;
    end
    ans_nxt = FieldW'(res_sel);
    if (ctl_r[N].fault != FAULT_NONE) begin
      ans_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vld_r[N];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ans_r <= ans_nxt;
      flt_r <= ctl_r[N].fault;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_data.answer = ans_r;
  assign out_data.fault  = flt_r;

endmodule
`default_nettype wire

[rtl/divider_64bit_signed_unsigned_unit.sv]
// Top level of the 64-bit signed and unsigned integer divide unit.
//
//  Channel | Ports                            | Payload
//  --------+----------------------------------+------------------------------------
//  input   | in_valid, in_stall, in_data      | opcode, dividend, divisor
//  result  | out_valid, out_stall, out_data   | answer, fault
//
// One transaction per cycle sustained while out_stall is low. From acceptance
// to result, the queue entry written at the accepting edge feeds
// DATA_WIDTH rows of the restoring divide pipeline (one quotient bit per row),
// then one output register.
// Reset (rst_n low, synchronous) empties the queue and the pipeline.
// A stall on the result side while out_valid is high freezes the pipeline; the
// queue then fills and raises in_stall after at most two more transactions.
`default_nettype none
module divider_64bit_signed_unsigned_unit
  import div64_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  // Queue between front and back: magnitudes plus sign/fault control.
  logic                  q_valid;
  logic                  q_stall;
  logic [DATA_WIDTH-1:0] q_num;
  logic [DATA_WIDTH-1:0] q_den;
  ctl_t                  q_ctl;

  // Front: decodes the opcode, flags zero divisor and signed overflow,
  // takes operand magnitudes.
  div64_front #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data (in_data),
    .q_valid (q_valid),
    .q_stall (q_stall),
    .q_num   (q_num),
    .q_den   (q_den),
    .q_ctl   (q_ctl)
  );

  // Back: pipelined restoring divide, sign correction, fault zeroing.
  div64_back #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_stall  (q_stall),
    .q_num    (q_num),
    .q_den    (q_den),
    .q_ctl    (q_ctl),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule
`default_nettype wire
